FILE: hw/rtl/adsl_pkg.sv
// ----------------------------------------------------------------------------
// adsl_pkg
// Shared widths, codes, reset values and arithmetic helpers of the actuator
// deadband and slew limiter.
// ----------------------------------------------------------------------------
package adsl_pkg;

  localparam int TIME_BITS_DEF = 32;

  // field widths
  localparam int NOW_W      = 32;
  localparam int CTRL_W     = 16;
  localparam int PHASE_W    = 8;
  localparam int PULSE_US_W = 11;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  // internal widths
  localparam int MILLI_W  = 21;  // pulse in milli-us, below 2^21
  localparam int WORK_W   = 23;  // signed working width for pulse arithmetic
  localparam int MAG_W    = 17;  // control magnitude, up to 32768
  localparam int Q_W      = 9;   // |integer part| of control, up to 327
  localparam int TARGET_W = 12;  // target pulse in us, 859..2141
  localparam int DT_W     = 21;  // saturated elapsed time

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_CODE   = 3'd5;

  // request kinds
  localparam logic FUNC_TICK      = 1'b0;
  localparam logic FUNC_TELEMETRY = 1'b1;

  // pulse limits in milli-us
  localparam logic [MILLI_W-1:0] NEUTRAL_MILLI = 21'd1500000;
  localparam logic [MILLI_W-1:0] MIN_MILLI     = 21'd1000000;
  localparam logic [MILLI_W-1:0] MAX_MILLI     = 21'd2000000;

  // slew limit cap: above every possible pulse change
  localparam logic [MILLI_W:0] MAXC_CAP = 22'h200000;

  // control map: target_us = trunc((ip + 255) * 100 / 51) + 1000
  localparam logic [Q_W-1:0]      MAP_OFFSET  = 9'd255;
  localparam logic [TARGET_W-1:0] MAP_BASE_US = 12'd1000;

  // reciprocal constants, exact over the value ranges used
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_100_SH = 19;
  localparam logic [16:0] RECIP_51     = 17'd82242;
  localparam int          RECIP_51_SH  = 22;
  localparam logic [20:0] RECIP_1000   = 21'd1073742;
  localparam int          RECIP_1000_SH = 30;

  // configuration reset values
  localparam logic        RST_DRIVE_ENABLED = 1'b1;
  localparam logic [14:0] RST_DEADBAND      = 15'd1000;
  localparam logic [11:0] RST_RAMP_RATE     = 12'd200;
  localparam logic [9:0]  RST_MIN_STEP      = 10'd5;
  localparam logic [15:0] RST_HOLD_TIMEOUT  = 16'd2000;
  localparam logic [7:0]  RST_IMPACT_CODE   = 8'd7;

  typedef struct packed {
    logic        drive_enabled;
    logic [14:0] deadband_hundredths;
    logic [11:0] ramp_rate_us_per_s;
    logic [9:0]  min_step_us;
    logic [15:0] hold_timeout_ms;
    logic [7:0]  impact_code;
  } cfg_t;

  // control value after deadband, reduced to sign and |integer part|
  typedef struct packed {
    logic           raw_nz;
    logic           db_nz;
    logic           neg;
    logic [Q_W-1:0] q;
  } front_t;

  function automatic front_t ctrl_front(input logic signed [CTRL_W-1:0] ctrl,
                                        input logic [14:0] deadband);
    logic signed [MAG_W-1:0] c_ext;
    logic [MAG_W-1:0]        mag;
    logic [29:0]             prod;
    logic                    below;
    front_t                  f;
    c_ext = MAG_W'(ctrl);
    mag   = ctrl[CTRL_W-1] ? unsigned'(-c_ext) : unsigned'(c_ext);
    prod  = 30'(mag) * 30'(RECIP_100);
    below = mag < MAG_W'(deadband);
    f.raw_nz = ctrl != '0;
    f.db_nz  = (ctrl != '0) && !below;
    f.neg    = ctrl[CTRL_W-1];
    f.q      = below ? '0 : Q_W'(prod >> RECIP_100_SH);
    return f;
  endfunction

  function automatic logic [TARGET_W-1:0] ip_to_target(input logic neg,
                                                       input logic [Q_W-1:0] q);
    logic [Q_W:0]  absn;
    logic          nneg;
    logic [15:0]   x;
    logic [32:0]   prod;
    logic [10:0]   quot;
    nneg = neg && (q > MAP_OFFSET);
    if (!neg) begin
      absn = (Q_W+1)'(q) + (Q_W+1)'(MAP_OFFSET);
    end else if (nneg) begin
      absn = (Q_W+1)'(q) - (Q_W+1)'(MAP_OFFSET);
    end else begin
      absn = (Q_W+1)'(MAP_OFFSET) - (Q_W+1)'(q);
    end
    x    = 16'(absn) * 16'd100;
    prod = 33'(x) * 33'(RECIP_51);
    quot = 11'(prod >> RECIP_51_SH);
    return nneg ? MAP_BASE_US - TARGET_W'(quot) : MAP_BASE_US + TARGET_W'(quot);
  endfunction

  function automatic logic [PULSE_US_W-1:0] milli_to_us(input logic [MILLI_W-1:0] p);
    logic [41:0] prod;
    prod = 42'(p) * 42'(RECIP_1000);
    return PULSE_US_W'(prod >> RECIP_1000_SH);
  endfunction

endpackage

FILE: hw/rtl/adsl_slew.sv
// ----------------------------------------------------------------------------
// adsl_slew
// One slew step: move the pulse toward the target by at most ramp * dt,
// skip small changes, clamp to the legal pulse range.
// ----------------------------------------------------------------------------
module adsl_slew
  import adsl_pkg::*;
(
  input  logic [MILLI_W-1:0]  pulse,
  input  logic [TARGET_W-1:0] target_us,
  input  logic [DT_W-1:0]     dt_sat,
  input  logic [11:0]         ramp_rate_us_per_s,
  input  logic [9:0]          min_step_us,
  output logic [MILLI_W-1:0]  pulse_next
);

  logic [MILLI_W:0]        target_milli;
  logic signed [WORK_W-1:0] change;
  logic [MILLI_W:0]        abs_change;
  logic [19:0]             step_lim;
  logic [32:0]             ramp_prod;
  logic [MILLI_W:0]        maxc;
  logic signed [WORK_W-1:0] maxc_s;
  logic signed [WORK_W-1:0] lim_change;
  logic signed [WORK_W-1:0] sum;

  always_comb begin
    target_milli = (MILLI_W+1)'(target_us) * 22'd1000;
    change       = $signed({1'b0, target_milli}) - $signed({2'b00, pulse});
    abs_change   = change[WORK_W-1] ? (MILLI_W+1)'(-change) : (MILLI_W+1)'(change);
    step_lim     = 20'(min_step_us) * 20'd1000;

    // ramp in us/s times ms gives milli-us directly
    ramp_prod = 33'(ramp_rate_us_per_s) * 33'(dt_sat);
    maxc      = (ramp_prod > 33'(MAXC_CAP)) ? MAXC_CAP : ramp_prod[MILLI_W:0];
    maxc_s    = $signed({1'b0, maxc});

    priority if (change > maxc_s) begin
      lim_change = maxc_s;
    end else if (change < -maxc_s) begin
      lim_change = -maxc_s;
    end else begin
      lim_change = change;
    end

    if (abs_change > (MILLI_W+1)'(step_lim)) begin
      sum = $signed({2'b00, pulse}) + lim_change;
    end else begin
      sum = $signed({2'b00, pulse});
    end

    priority if (sum < $signed({2'b00, MIN_MILLI})) begin
      pulse_next = MIN_MILLI;
    end else if (sum > $signed({2'b00, MAX_MILLI})) begin
      pulse_next = MAX_MILLI;
    end else begin
      pulse_next = MILLI_W'(sum);
    end
  end

endmodule

FILE: hw/rtl/actuator_deadband_slew_limiter.sv
// ----------------------------------------------------------------------------
// actuator_deadband_slew_limiter
// Pipeline: the accept edge loads the first of four register stages (control map,
//   target map, state update, pulse conversion).
// Throughput: one request per cycle while m_tready does not stall the output; the
//   state update is computed and registered within stage 3.
// Reset: rst (sync, high) empties the pipeline, parks the pulse at neutral,
//   clears the wheel and time state and loads the register defaults.
// ----------------------------------------------------------------------------
module actuator_deadband_slew_limiter
  import adsl_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: now_ms[31:0], ctrl_hundredths[47:32], flight_phase[55:48]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: func[0]
  input  logic                  s_tuser,
  // m_tdata: pulse_us[10:0], pulse_written[11], wheel_on[12], timeout_stop[13], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef logic [TIME_BITS-1:0] time_t;

  cfg_t cfg;

  // pipeline control
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: control value reduced
  logic                 s1_func;
  time_t                s1_now;
  logic [PHASE_W-1:0]   s1_phase;
  front_t               s1_front;

  // stage 2: target pulse
  logic                 s2_func;
  time_t                s2_now;
  logic [PHASE_W-1:0]   s2_phase;
  logic                 s2_raw_nz;
  logic                 s2_db_nz;
  logic [TARGET_W-1:0]  s2_target;

  // stage 3: flags of the item that last updated the state
  logic                 s3_written;
  logic                 s3_tstop;

  // wheel state
  logic [MILLI_W-1:0]   pulse_milli;
  logic                 active;
  time_t                last_step;
  logic                 step_valid;
  time_t                last_update;

  logic [MILLI_W-1:0]   pulse_milli_next;
  logic                 active_next;
  time_t                last_step_next;
  logic                 step_valid_next;
  time_t                last_update_next;
  logic                 written_c;
  logic                 tstop_c;

  time_t                dt;
  time_t                idle_time;
  logic [DT_W-1:0]      dt_sat;
  logic [MILLI_W-1:0]   slew_pulse;

  logic [PULSE_US_W-1:0] out_pulse_us;
  logic                  out_written;
  logic                  out_wheel;
  logic                  out_tstop;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_enabled       <= RST_DRIVE_ENABLED;
      cfg.deadband_hundredths <= RST_DEADBAND;
      cfg.ramp_rate_us_per_s  <= RST_RAMP_RATE;
      cfg.min_step_us         <= RST_MIN_STEP;
      cfg.hold_timeout_ms     <= RST_HOLD_TIMEOUT;
      cfg.impact_code         <= RST_IMPACT_CODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DRIVE_ENABLED: cfg.drive_enabled       <= cfg_data[0];
        REG_DEADBAND:      cfg.deadband_hundredths <= cfg_data[14:0];
        REG_RAMP_RATE:     cfg.ramp_rate_us_per_s  <= cfg_data[11:0];
        REG_MIN_STEP:      cfg.min_step_us         <= cfg_data[9:0];
        REG_HOLD_TIMEOUT:  cfg.hold_timeout_ms     <= cfg_data[15:0];
        REG_IMPACT_CODE:   cfg.impact_code         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      s1_func  <= s_tuser;
      s1_now   <= time_t'(s_tdata[NOW_W-1:0]);
      s1_phase <= s_tdata[IN_DATA_W-1:NOW_W+CTRL_W];
      s1_front <= ctrl_front(s_tdata[NOW_W+CTRL_W-1:NOW_W], cfg.deadband_hundredths);
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_func   <= s1_func;
      s2_now    <= s1_now;
      s2_phase  <= s1_phase;
      s2_raw_nz <= s1_front.raw_nz;
      s2_db_nz  <= s1_front.db_nz;
      s2_target <= ip_to_target(s1_front.neg, s1_front.q);
    end
  end

  // ---------------------------------------------------------------- stage 3
  assign dt        = s2_now - last_step;
  assign idle_time = s2_now - last_update;
  assign dt_sat    = ((dt >> DT_W) != '0) ? '1 : DT_W'(dt);

  adsl_slew u_slew (
    .pulse              (pulse_milli),
    .target_us          (s2_target),
    .dt_sat             (dt_sat),
    .ramp_rate_us_per_s (cfg.ramp_rate_us_per_s),
    .min_step_us        (cfg.min_step_us),
    .pulse_next         (slew_pulse)
  );

  always_comb begin
    pulse_milli_next = pulse_milli;
    active_next      = active;
    last_step_next   = last_step;
    step_valid_next  = step_valid;
    last_update_next = last_update;
    written_c        = 1'b0;
    tstop_c          = 1'b0;

    priority if (s2_func == FUNC_TICK) begin
      // stop an active wheel that has gone too long without an update
      if (active && (idle_time > time_t'(cfg.hold_timeout_ms)) && cfg.drive_enabled) begin
        pulse_milli_next = NEUTRAL_MILLI;
        active_next      = 1'b0;
        written_c        = 1'b1;
        tstop_c          = 1'b1;
      end
    end else if (s2_phase == cfg.impact_code) begin
      if (active && cfg.drive_enabled) begin
        pulse_milli_next = NEUTRAL_MILLI;
        active_next      = 1'b0;
        written_c        = 1'b1;
      end
    end else if (s2_raw_nz || active) begin
      last_update_next = s2_now;
      if (cfg.drive_enabled) begin
        if (!step_valid || (dt == '0)) begin
          // first step or no time elapsed: only latch the time base
          last_step_next  = s2_now;
          step_valid_next = 1'b1;
        end else begin
          if (s2_db_nz) begin
            active_next = 1'b1;
          end
          pulse_milli_next = slew_pulse;
          last_step_next   = s2_now;
          written_c        = 1'b1;
        end
      end
    end else begin
      // idle wheel with zero control: hold everything
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3          <= 1'b0;
      pulse_milli <= NEUTRAL_MILLI;
      active      <= 1'b0;
      last_step   <= '0;
      step_valid  <= 1'b0;
      last_update <= '0;
    end else if (rdy3) begin
      v3 <= v2;
      if (v2) begin
        pulse_milli <= pulse_milli_next;
        active      <= active_next;
        last_step   <= last_step_next;
        step_valid  <= step_valid_next;
        last_update <= last_update_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_written <= written_c;
      s3_tstop   <= tstop_c;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // the wheel state changes only when stage 3 loads, so it still belongs to
  // the item held in stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out_pulse_us <= milli_to_us(pulse_milli);
      out_written  <= s3_written;
      out_wheel    <= active;
      out_tstop    <= s3_tstop;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {2'b00, out_tstop, out_wheel, out_written, out_pulse_us};

endmodule

FILE: verif/tb_actuator_deadband_slew_limiter.sv
// ----------------------------------------------------------------------------
// tb_actuator_deadband_slew_limiter
// Self-checking bench for the deadband and slew limiter. A queue of requests
// and register writes feeds a stream driver. A monitor predicts each accepted
// request with a behavioral model of the wheel drive and checks every result
// in order. Both stream sides stall at random. A directed opening is followed
// by random runs under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_actuator_deadband_slew_limiter;
  import adsl_pkg::*;

  localparam int     LIMIT_CYCLES = 200000;
  localparam int     TAIL_CYCLES  = 20;
  localparam longint NEUTRAL_MU   = 1500000;
  localparam longint FLOOR_MU     = 1000000;
  localparam longint CEIL_MU      = 2000000;

  typedef struct packed {
    logic                  is_cfg;
    logic                  func;
    logic [NOW_W-1:0]      now;
    logic [CTRL_W-1:0]     ctrl;
    logic [PHASE_W-1:0]    phase;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic [PULSE_US_W-1:0] pulse_us;
    logic                  written;
    logic                  wheel_on;
    logic                  timeout_stop;
  } drive_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = FUNC_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  request_t      pending_ops[$];
  drive_result_t pending_pulses[$];
  logic          s_taken = 1'b0;
  logic          cfg_taken = 1'b0;
  logic          stim_idle = 1'b0;
  int            fail_count = 0;
  int            drive_cyc = 0;
  int            watchdog = 0;

  // stimulus planning state
  logic [NOW_W-1:0] clock_ms;
  int               plan_db = RST_DEADBAND;
  int               plan_impact = RST_IMPACT_CODE;

  // wheel model state
  cfg_t   pred_cfg = '{RST_DRIVE_ENABLED, RST_DEADBAND, RST_RAMP_RATE,
                       RST_MIN_STEP, RST_HOLD_TIMEOUT, RST_IMPACT_CODE};
  longint pred_pulse = NEUTRAL_MU;
  logic   pred_active = 1'b0;
  logic [NOW_W-1:0] pred_step_ms = '0;
  logic   pred_step_ok = 1'b0;
  logic [NOW_W-1:0] pred_update_ms = '0;

  actuator_deadband_slew_limiter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic stop_wheel();
    if (!pred_cfg.drive_enabled) return 1'b0;
    pred_pulse  = NEUTRAL_MU;
    pred_active = 1'b0;
    return 1'b1;
  endfunction

  function automatic drive_result_t predict_drive(input logic fn,
                                                  input logic [NOW_W-1:0] now,
                                                  input logic signed [CTRL_W-1:0] ctrl_in,
                                                  input logic [PHASE_W-1:0] ph);
    drive_result_t r;
    logic [NOW_W-1:0] dt;
    int     ctrl, mag, ip;
    longint target, change, maxc, dt_l, ramp_l, min_l;
    logic   wr, ts;
    wr   = 1'b0;
    ts   = 1'b0;
    ctrl = ctrl_in;
    if (fn == FUNC_TELEMETRY) begin
      if (ph == pred_cfg.impact_code) begin
        if (pred_active) wr = stop_wheel();
      end else if (ctrl != 0 || pred_active) begin
        pred_update_ms = now;
        if (pred_cfg.drive_enabled) begin
          dt = now - pred_step_ms;
          if (!pred_step_ok || dt == '0) begin
            // first step or no time elapsed: only latch the time base
            pred_step_ms = now;
            pred_step_ok = 1'b1;
          end else begin
            mag = (ctrl < 0) ? -ctrl : ctrl;
            if (mag < int'(pred_cfg.deadband_hundredths)) ctrl = 0;
            if (ctrl != 0) pred_active = 1'b1;
            ip     = ctrl / 100;
            target = ((longint'(ip) + 255) * 1000) / 510 + 1000;
            target = target * 1000;
            // elapsed time fits in 32 bits, so no saturation is needed
            dt_l   = dt;
            ramp_l = pred_cfg.ramp_rate_us_per_s;
            min_l  = pred_cfg.min_step_us;
            maxc   = ramp_l * dt_l;
            change = target - pred_pulse;
            if (((change < 0) ? -change : change) > min_l * 1000) begin
              if (change > maxc) change = maxc;
              if (change < -maxc) change = -maxc;
              pred_pulse = pred_pulse + change;
            end
            if (pred_pulse < FLOOR_MU) pred_pulse = FLOOR_MU;
            if (pred_pulse > CEIL_MU) pred_pulse = CEIL_MU;
            pred_step_ms = now;
            wr = 1'b1;
          end
        end
      end
    end else if (pred_active && (now - pred_update_ms) > pred_cfg.hold_timeout_ms) begin
      ts = stop_wheel();
      wr = ts;
    end
    r.pulse_us     = PULSE_US_W'(pred_pulse / 1000);
    r.written      = wr;
    r.wheel_on     = pred_active;
    r.timeout_stop = ts;
    return r;
  endfunction

  task automatic queue_request(input logic fn, input logic [NOW_W-1:0] now,
                               input int c, input int ph);
    request_t q;
    q        = '0;
    q.func   = fn;
    q.now    = now;
    q.ctrl   = CTRL_W'(c);
    q.phase  = PHASE_W'(ph);
    pending_ops.push_back(q);
  endtask

  task automatic queue_reg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    request_t q;
    q        = '0;
    q.is_cfg = 1'b1;
    q.idx    = idx;
    q.data   = CFG_DATA_W'(value);
    pending_ops.push_back(q);
    if (idx == REG_DEADBAND) plan_db = value;
    if (idx == REG_IMPACT_CODE) plan_impact = value;
  endtask

  // mostly plausible telemetry timelines, with stalls, jumps and wraps mixed in
  task automatic queue_random_run(input int n);
    int    sel, c, m, ph;
    logic  fn;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        clock_ms = clock_ms;
      end else if (sel < 75) begin
        clock_ms = clock_ms + $urandom_range(1, 40);
      end else if (sel < 92) begin
        clock_ms = clock_ms + $urandom_range(41, 3000);
      end else if (sel < 95) begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
      end else begin
        clock_ms = $urandom;
      end
      fn  = ($urandom_range(99) < 25) ? FUNC_TICK : FUNC_TELEMETRY;
      sel = $urandom_range(99);
      if (sel < 15) begin
        c = 0;
      end else if (sel < 35) begin
        m = plan_db + int'($urandom_range(0, 4)) - 2;
        if (m < 0) m = 0;
        if (m > 32767) m = 32767;
        c = $urandom_range(1) ? -m : m;
      end else if (sel < 45) begin
        c = $urandom_range(1) ? 32767 : (($urandom_range(1) != 0) ? -32768 : -32767);
      end else begin
        c = int'($signed(16'($urandom)));
      end
      sel = $urandom_range(99);
      if (sel < 10) ph = plan_impact;
      else if (sel < 25) ph = $urandom_range(255);
      else ph = $urandom_range(15);
      queue_request(fn, clock_ms, c, ph);
    end
  endtask

  // driver: present queued requests and register writes at the falling edge
  always @(negedge clk) begin : drive_requests
    request_t              nxt;
    logic                  sv, cv, su, calm;
    logic [IN_DATA_W-1:0]  sd;
    logic [CFG_IDX_W-1:0]  ci;
    logic [CFG_DATA_W-1:0] cd;
    if (!rst) begin
      drive_cyc = drive_cyc + 1;
      calm = (drive_cyc >= 800) && (drive_cyc < 1400);
      sv = s_tvalid && !s_taken;
      cv = cfg_valid && !cfg_taken;
      sd = s_tdata;
      su = s_tuser;
      ci = cfg_index;
      cd = cfg_data;
      if (!sv && !cv && pending_ops.size() != 0) begin
        nxt = pending_ops[0];
        if (nxt.is_cfg) begin
          // write registers only with the pipeline drained
          if (pending_pulses.size() == 0) begin
            cv = 1'b1;
            ci = nxt.idx;
            cd = nxt.data;
            void'(pending_ops.pop_front());
          end
        end else if (calm || $urandom_range(99) >= 17) begin
          sv = 1'b1;
          sd = {nxt.phase, nxt.ctrl, nxt.now};
          su = nxt.func;
          void'(pending_ops.pop_front());
        end
      end
      s_tvalid  <= sv;
      s_tdata   <= sd;
      s_tuser   <= su;
      cfg_valid <= cv;
      cfg_index <= ci;
      cfg_data  <= cd;
      m_tready  <= calm || ($urandom_range(99) >= 17);
      stim_idle <= (pending_ops.size() == 0) && !sv && !cv;
    end
  end

  // monitor: predict on accept, check results in order
  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (!rst) begin
      s_taken   <= s_tvalid && s_tready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRIVE_ENABLED: pred_cfg.drive_enabled       = cfg_data[0];
          REG_DEADBAND:      pred_cfg.deadband_hundredths = cfg_data[14:0];
          REG_RAMP_RATE:     pred_cfg.ramp_rate_us_per_s  = cfg_data[11:0];
          REG_MIN_STEP:      pred_cfg.min_step_us         = cfg_data[9:0];
          REG_HOLD_TIMEOUT:  pred_cfg.hold_timeout_ms     = cfg_data[15:0];
          REG_IMPACT_CODE:   pred_cfg.impact_code         = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        pending_pulses.push_back(predict_drive(s_tuser, s_tdata[31:0],
                                               s_tdata[47:32], s_tdata[55:48]));
      end
      if (m_tvalid && m_tready) begin
        if (pending_pulses.size() == 0) begin
          $error("unexpected result: m_tdata %h", m_tdata);
          fail_count = fail_count + 1;
        end else begin
          want = pending_pulses.pop_front();
          if (m_tdata[10:0] !== want.pulse_us) begin
            $error("pulse_us: expected %0d, got %0d", want.pulse_us, m_tdata[10:0]);
            fail_count = fail_count + 1;
          end
          if (m_tdata[11] !== want.written) begin
            $error("pulse_written: expected %0d, got %0d", want.written, m_tdata[11]);
            fail_count = fail_count + 1;
          end
          if (m_tdata[12] !== want.wheel_on) begin
            $error("wheel_on: expected %0d, got %0d", want.wheel_on, m_tdata[12]);
            fail_count = fail_count + 1;
          end
          if (m_tdata[13] !== want.timeout_stop) begin
            $error("timeout_stop: expected %0d, got %0d", want.timeout_stop, m_tdata[13]);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : run_watchdog
    watchdog = watchdog + 1;
    if (watchdog >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // directed opening under reset settings
    queue_request(FUNC_TICK,      32'd0,    0,      0);   // tick on an idle wheel
    queue_request(FUNC_TELEMETRY, 32'd10,   0,      0);   // zero control, idle wheel
    queue_request(FUNC_TELEMETRY, 32'd20,   5000,   7);   // impact on an idle wheel
    queue_request(FUNC_TELEMETRY, 32'd100,  32767,  255); // latch time base
    queue_request(FUNC_TELEMETRY, 32'd100,  32767,  1);   // no time elapsed
    queue_request(FUNC_TELEMETRY, 32'd1100, 32767,  2);
    queue_request(FUNC_TELEMETRY, 32'd1110, 32767,  2);
    queue_request(FUNC_TELEMETRY, 32'd4000, -32768, 3);
    queue_request(FUNC_TELEMETRY, 32'd6000, -32768, 3);   // clamp at the floor
    queue_request(FUNC_TELEMETRY, 32'd6500, 999,    4);   // just inside the deadband
    queue_request(FUNC_TELEMETRY, 32'd7000, -999,   4);
    queue_request(FUNC_TELEMETRY, 32'd7100, 1000,   5);   // at the deadband edge
    queue_request(FUNC_TELEMETRY, 32'd7200, -1000,  5);
    queue_request(FUNC_TELEMETRY, 32'd7300, -13300, 6);   // change below the minimum step
    queue_request(FUNC_TICK,      32'd9300, 0,      0);   // exactly at the hold timeout
    queue_request(FUNC_TICK,      32'd9301, 0,      0);   // past the hold timeout
    queue_request(FUNC_TELEMETRY, 32'd9400, 32767,  0);
    queue_request(FUNC_TELEMETRY, 32'd9500, 100,    7);   // impact on an active wheel
    queue_request(FUNC_TELEMETRY, 32'hFFFF_FF00, 20000, 8);
    queue_request(FUNC_TELEMETRY, 32'h0000_0010, -20000, 9); // time stamp wraps
    queue_request(FUNC_TICK,      32'h0000_0020, 0,     0);
    queue_request(FUNC_TELEMETRY, 32'h0000_0030, 32767, 6);  // leave the wheel active
    clock_ms = 32'h0000_0030;

    // drive off: stops and control updates are ignored
    queue_reg_write(REG_DRIVE_ENABLED, 0);
    queue_random_run(40);

    queue_reg_write(REG_DRIVE_ENABLED, 1);
    queue_reg_write(REG_DEADBAND, 0);
    queue_reg_write(REG_RAMP_RATE, 4000);
    queue_reg_write(REG_MIN_STEP, 0);
    queue_reg_write(REG_HOLD_TIMEOUT, 0);
    queue_reg_write(REG_IMPACT_CODE, 0);
    queue_random_run(400);

    queue_reg_write(REG_DEADBAND, 32767);
    queue_reg_write(REG_RAMP_RATE, 0);
    queue_reg_write(REG_MIN_STEP, 1000);
    queue_reg_write(REG_HOLD_TIMEOUT, 65535);
    queue_reg_write(REG_IMPACT_CODE, 255);
    queue_random_run(250);

    for (int k = 0; k < 3; k++) begin
      queue_reg_write(REG_DEADBAND, ($urandom_range(3) == 0) ? $urandom_range(32767)
                                                             : $urandom_range(3000));
      queue_reg_write(REG_RAMP_RATE, $urandom_range(4000));
      queue_reg_write(REG_MIN_STEP, ($urandom_range(3) == 0) ? $urandom_range(1000)
                                                             : $urandom_range(50));
      queue_reg_write(REG_HOLD_TIMEOUT, $urandom_range(5000));
      queue_reg_write(REG_IMPACT_CODE, $urandom_range(255));
      queue_random_run(320);
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // drain: all requests out and every result back
    @(negedge clk);
    while (!stim_idle || pending_pulses.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
